### rtl/hals_pkg.sv
// ----------------------------------------------------------------------------
// hals_pkg
// Shared types and constants of the auto-levels contrast stretch.
// ----------------------------------------------------------------------------
package hals_pkg;

   localparam int COUNT_BITS  = 24;
   localparam int BIN_BITS    = 8;
   localparam int NUM_BINS    = 1 << BIN_BITS;
   localparam int LEVEL_BITS  = BIN_BITS + 1;
   localparam int CUT_BITS    = 15;
   localparam int FRAC_BITS   = 16;
   localparam int CUM_BITS    = COUNT_BITS + BIN_BITS;
   localparam int TARGET_BITS = CUT_BITS + COUNT_BITS;
   localparam int CMP_BITS    = CUM_BITS + FRAC_BITS;
   localparam int NUM_BITS    = 2 * BIN_BITS;
   localparam int DEN_BITS    = BIN_BITS;
   localparam int DIV_CNT_BITS = $clog2(NUM_BITS);
   localparam int ADDR_BITS   = 3;
   localparam int DATA_BITS   = 32;

   localparam logic [CUT_BITS-1:0]   CUT_RESET  = CUT_BITS'(328);
   localparam logic [LEVEL_BITS-1:0] LOW_RESET  = '0;
   localparam logic [LEVEL_BITS-1:0] HIGH_RESET = LEVEL_BITS'(255);
   localparam logic [BIN_BITS-1:0]   PIX_MAX    = '1;
   localparam logic [ADDR_BITS-1:0]  CSR_CUT_ADDR = '0;

   typedef enum logic [1:0] {
      CMD_CLEAR   = 2'd0,
      CMD_ACCUM   = 2'd1,
      CMD_COMPUTE = 2'd2,
      CMD_MAP     = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_INVALID = 2'd1,
      STATUS_SAT     = 2'd2
   } status_type;

   typedef struct packed {
      logic                start;
      cmd_type             cmd;
      logic [BIN_BITS-1:0] pixel;
   } hist_req_type;

   typedef struct packed {
      logic                          done;
      logic                          sat;
      logic                          total_nz;
      logic [LEVEL_BITS-1:0]         lo;
      logic signed [LEVEL_BITS-1:0]  hi;
   } hist_rsp_type;

   typedef struct packed {
      logic                done;
      logic [NUM_BITS-1:0] quo;
      logic [DEN_BITS-1:0] rem;
   } div_rsp_type;

endpackage

### rtl/hals_div.sv
// ----------------------------------------------------------------------------
// hals_div
// Restoring divider, one quotient bit per cycle, for the map scaling.
// ----------------------------------------------------------------------------
module hals_div
   import hals_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NUM_BITS-1:0] num,
   input  logic [DEN_BITS-1:0] den,
   output div_rsp_type         rsp
);

   logic [NUM_BITS-1:0]     quo_ff;
   logic [DEN_BITS-1:0]     rem_ff;
   logic [DEN_BITS-1:0]     den_ff;
   logic [DIV_CNT_BITS-1:0] cnt_ff;
   logic                    busy_ff;
   logic                    done_ff;
   logic [DEN_BITS:0]       trial;
   logic                    fits;

   assign trial = {rem_ff, quo_ff[NUM_BITS-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == '1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= num;
         rem_ff <= '0;
         den_ff <= den;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[NUM_BITS-2:0], fits};
         rem_ff <= fits ? DEN_BITS'(trial - {1'b0, den_ff}) : trial[DEN_BITS-1:0];
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = quo_ff;
   assign rsp.rem  = rem_ff;

endmodule

### rtl/hals_hist.sv
// ----------------------------------------------------------------------------
// hals_hist
// Histogram memory with per-bin valid flags, accumulate read-modify-write and
// the percentile scans for the lower and upper levels.
// ----------------------------------------------------------------------------
module hals_hist
   import hals_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  hist_req_type        req,
   input  logic [CUT_BITS-1:0] cut_q16,
   output hist_rsp_type        rsp
);

   typedef enum logic [6:0] {
      H_IDLE   = 7'b0000001,
      H_ACC    = 7'b0000010,
      H_LO_CHK = 7'b0000100,
      H_LO_ADD = 7'b0001000,
      H_HI_CHK = 7'b0010000,
      H_HI_ADD = 7'b0100000,
      H_DONE   = 7'b1000000
   } hist_state_type;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   hist_state_type               state_ff, state_in;
   logic [COUNT_BITS-1:0]        bin_mem_ff [NUM_BINS];
   logic [COUNT_BITS-1:0]        rdata_ff;
   logic                         rvalid_ff;
   logic [NUM_BINS-1:0]          valid_ff;
   logic [COUNT_BITS-1:0]        total_ff;
   logic [TARGET_BITS-1:0]       target_ff;
   logic [CUM_BITS-1:0]          cum_ff;
   logic [LEVEL_BITS-1:0]        lo_ff;
   logic signed [LEVEL_BITS-1:0] hi_ff;
   logic [BIN_BITS-1:0]          pix_ff;
   logic                         sat_ff;

   logic [BIN_BITS-1:0]          rd_addr;
   logic [COUNT_BITS-1:0]        bin_word;
   logic                         below;
   logic                         bin_full;
   logic                         total_full;

   assign bin_word   = rvalid_ff ? rdata_ff : '0;
   assign below      = {cum_ff, {FRAC_BITS{1'b0}}} < CMP_BITS'(target_ff);
   assign bin_full   = bin_word == COUNT_MAX;
   assign total_full = total_ff == COUNT_MAX;

   always_comb begin
      priority if (state_ff == H_LO_CHK) begin
         rd_addr = lo_ff[BIN_BITS-1:0];
      end else if (state_ff == H_HI_CHK) begin
         rd_addr = hi_ff[BIN_BITS-1:0];
      end else begin
         rd_addr = req.pixel;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         H_IDLE: begin
            if (req.start) begin
               unique case (req.cmd)
                  CMD_ACCUM:   state_in = H_ACC;
                  CMD_COMPUTE: state_in = H_LO_CHK;
                  default:     state_in = H_DONE;
               endcase
            end
         end
         H_ACC:    state_in = H_DONE;
         H_LO_CHK: state_in = (!lo_ff[BIN_BITS] && below) ? H_LO_ADD : H_HI_CHK;
         H_LO_ADD: state_in = H_LO_CHK;
         H_HI_CHK: state_in = (!hi_ff[BIN_BITS] && below) ? H_HI_ADD : H_DONE;
         H_HI_ADD: state_in = H_HI_CHK;
         H_DONE:   state_in = H_IDLE;
         default:  state_in = H_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      rdata_ff  <= bin_mem_ff[rd_addr];
      rvalid_ff <= valid_ff[rd_addr];
      if (state_ff == H_ACC) begin
         bin_mem_ff[pix_ff] <= bin_full ? COUNT_MAX : bin_word + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= H_IDLE;
         valid_ff <= '0;
         total_ff <= '0;
         lo_ff    <= LOW_RESET;
         hi_ff    <= HIGH_RESET;
         sat_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == H_IDLE && req.start) begin
            sat_ff <= 1'b0;
            if (req.cmd == CMD_CLEAR) begin
               valid_ff <= '0;
               total_ff <= '0;
            end else if (req.cmd == CMD_COMPUTE) begin
               lo_ff <= '0;
               hi_ff <= HIGH_RESET;
            end
         end
         if (state_ff == H_ACC) begin
            valid_ff[pix_ff] <= 1'b1;
            total_ff         <= total_full ? COUNT_MAX : total_ff + 1'b1;
            sat_ff           <= bin_full || total_full;
         end
         if (state_ff == H_LO_ADD) begin
            lo_ff <= lo_ff + 1'b1;
         end
         if (state_ff == H_HI_ADD) begin
            hi_ff <= hi_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == H_IDLE && req.start) begin
         pix_ff    <= req.pixel;
         target_ff <= TARGET_BITS'(cut_q16) * TARGET_BITS'(total_ff);
         cum_ff    <= '0;
      end else if (state_ff == H_LO_ADD || state_ff == H_HI_ADD) begin
         cum_ff <= cum_ff + CUM_BITS'(bin_word);
      end else if (state_ff == H_LO_CHK && state_in == H_HI_CHK) begin
         cum_ff <= '0;
      end
   end

   assign rsp.done     = state_ff == H_DONE;
   assign rsp.sat      = sat_ff;
   assign rsp.total_nz = total_ff != '0;
   assign rsp.lo       = lo_ff;
   assign rsp.hi       = hi_ff;

endmodule

### rtl/histogram_auto_levels_stretch.sv
// ----------------------------------------------------------------------------
// histogram_auto_levels_stretch
// Result word paths: clear and accumulate (one read-modify-write of the bin
// memory) run through the histogram, map with invalid levels or at/below the
// low level skips the divider, else uses the serial divider, compute scans bins.
// One word in flight; next word taken once the result sits in the output reg.
// Reset: histogram empty via per-bin valid flags (no clearing pass),
// cut_q16 = 328, levels 0 and 255, levels invalid.
// ----------------------------------------------------------------------------
module histogram_auto_levels_stretch
   import hals_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_cmd,
   input  logic [BIN_BITS-1:0]          req_pixel,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [BIN_BITS-1:0]          rsp_pixel_out,
   output logic [LEVEL_BITS-1:0]        rsp_low_level,
   output logic signed [LEVEL_BITS-1:0] rsp_high_level,
   output logic [1:0]                   rsp_status,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [ADDR_BITS-1:0]         csr_paddr,
   input  logic [DATA_BITS-1:0]         csr_pwdata,
   output logic [DATA_BITS-1:0]         csr_prdata,
   output logic                         csr_pready
);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_HIST   = 4'b0010,
      S_DIV    = 4'b0100,
      S_FINISH = 4'b1000
   } top_state_type;

   top_state_type                state_ff, state_in;
   logic [CUT_BITS-1:0]          cut_ff;
   logic [LEVEL_BITS-1:0]        lower_ff;
   logic signed [LEVEL_BITS-1:0] upper_ff;
   logic                         levels_valid_ff;
   cmd_type                      cmd_ff;
   logic [BIN_BITS-1:0]          pend_pix_ff;
   status_type                   pend_status_ff;
   logic                         rsp_valid_ff;
   logic [BIN_BITS-1:0]          rsp_pix_ff;
   logic [LEVEL_BITS-1:0]        rsp_low_ff;
   logic signed [LEVEL_BITS-1:0] rsp_high_ff;
   status_type                   rsp_status_ff;

   hist_req_type                 hist_req;
   hist_rsp_type                 hist_rsp;
   div_rsp_type                  div_rsp;

   logic                         accept;
   cmd_type                      cmd;
   logic                         out_free;
   logic                         at_or_below;
   logic [BIN_BITS-1:0]          diff;
   logic [NUM_BITS-1:0]          num;
   logic [DEN_BITS-1:0]          den;
   logic                         div_start;
   logic                         new_valid;
   logic [DEN_BITS:0]            two_rem;
   logic                         round_up;
   logic [NUM_BITS:0]            quo_rnd;
   logic [BIN_BITS-1:0]          quo_clamped;

   assign cmd       = cmd_type'(req_cmd);
   assign accept    = req_valid && state_ff == S_IDLE;
   assign req_stall = state_ff != S_IDLE;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign at_or_below = {1'b0, req_pixel} <= lower_ff;
   assign diff        = req_pixel - lower_ff[BIN_BITS-1:0];
   assign num         = NUM_BITS'({diff, {BIN_BITS{1'b0}}}) - NUM_BITS'(diff);
   assign den         = upper_ff[BIN_BITS-1:0] - lower_ff[BIN_BITS-1:0];
   assign div_start   = accept && cmd == CMD_MAP && levels_valid_ff && !at_or_below;

   assign new_valid = hist_rsp.total_nz &&
                      ($signed({hist_rsp.hi[LEVEL_BITS-1], hist_rsp.hi}) >
                       $signed({1'b0, hist_rsp.lo}));

   assign two_rem  = {div_rsp.rem, 1'b0};
   assign round_up = (two_rem > {1'b0, den}) ||
                     (two_rem == {1'b0, den} && div_rsp.quo[0]);
   assign quo_rnd  = {1'b0, div_rsp.quo} + (NUM_BITS+1)'(round_up);
   assign quo_clamped = (quo_rnd > (NUM_BITS+1)'(PIX_MAX)) ? PIX_MAX
                                                           : quo_rnd[BIN_BITS-1:0];

   assign hist_req.start = accept && cmd != CMD_MAP;
   assign hist_req.cmd   = cmd;
   assign hist_req.pixel = req_pixel;

   hals_hist u_hist (
      .clock   (clock),
      .reset   (reset),
      .req     (hist_req),
      .cut_q16 (cut_ff),
      .rsp     (hist_rsp)
   );

   hals_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num),
      .den   (den),
      .rsp   (div_rsp)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (cmd != CMD_MAP) begin
                  state_in = S_HIST;
               end else if (div_start) begin
                  state_in = S_DIV;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_HIST:   state_in = hist_rsp.done ? S_FINISH : S_HIST;
         S_DIV:    state_in = div_rsp.done ? S_FINISH : S_DIV;
         S_FINISH: state_in = out_free ? S_IDLE : S_FINISH;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         cut_ff          <= CUT_RESET;
         lower_ff        <= LOW_RESET;
         upper_ff        <= HIGH_RESET;
         levels_valid_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_psel && csr_penable && csr_pwrite && csr_paddr == CSR_CUT_ADDR) begin
            cut_ff <= csr_pwdata[CUT_BITS-1:0];
         end
         if (state_ff == S_HIST && hist_rsp.done && cmd_ff == CMD_COMPUTE) begin
            lower_ff        <= hist_rsp.lo;
            upper_ff        <= hist_rsp.hi;
            levels_valid_ff <= new_valid;
         end
         if (state_ff == S_FINISH && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= cmd;
         if (cmd == CMD_MAP && !levels_valid_ff) begin
            pend_pix_ff    <= req_pixel;
            pend_status_ff <= STATUS_INVALID;
         end else begin
            pend_pix_ff    <= '0;
            pend_status_ff <= STATUS_OK;
         end
      end
      if (state_ff == S_HIST && hist_rsp.done) begin
         unique case (cmd_ff)
            CMD_ACCUM:   pend_status_ff <= hist_rsp.sat ? STATUS_SAT : STATUS_OK;
            CMD_COMPUTE: pend_status_ff <= new_valid ? STATUS_OK : STATUS_INVALID;
            default:     pend_status_ff <= STATUS_OK;
         endcase
      end
      if (state_ff == S_DIV && div_rsp.done) begin
         pend_pix_ff <= quo_clamped;
      end
      if (state_ff == S_FINISH && out_free) begin
         rsp_pix_ff    <= pend_pix_ff;
         rsp_low_ff    <= lower_ff;
         rsp_high_ff   <= upper_ff;
         rsp_status_ff <= pend_status_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_out  = rsp_pix_ff;
   assign rsp_low_level  = rsp_low_ff;
   assign rsp_high_level = rsp_high_ff;
   assign rsp_status     = rsp_status_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_CUT_ADDR) ? DATA_BITS'(cut_ff) : '0;

   a_levels_ordered : assert property (@(posedge clock) disable iff (reset)
      levels_valid_ff |-> ($signed({upper_ff[LEVEL_BITS-1], upper_ff}) >
                           $signed({1'b0, lower_ff})))
      else $error("valid levels with upper not above lower");

   a_hist_done_owned : assert property (@(posedge clock) disable iff (reset)
      hist_rsp.done |-> state_ff == S_HIST)
      else $error("histogram completion outside histogram wait");

   a_div_done_owned : assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == S_DIV)
      else $error("divider completion outside map wait");

   a_one_in_flight : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second word taken while one is in flight");

endmodule

### test/tb_histogram_auto_levels_stretch.sv
// ----------------------------------------------------------------------------
// tb_histogram_auto_levels_stretch
// Self-checking bench for the auto-levels contrast stretch. A queue of
// command words (clear, accumulate, compute, map) is played into the block
// by a clocked driver with random gaps. A clocked monitor applies random
// back-pressure and compares every result word, field by field, against a
// software histogram and level model updated on each accepted word. The
// clip fraction is reprogrammed over APB between phases, both extremes
// included.
// ----------------------------------------------------------------------------
module tb_histogram_auto_levels_stretch;
   import hals_pkg::*;

   localparam int CYCLE_LIMIT   = 5_000_000;
   localparam int SETTLE_CYCLES = 1100;
   localparam int PHASE_WORDS   = 40;
   localparam int MAX_REPORTS   = 20;

   typedef struct {
      cmd_type             cmd;
      logic [BIN_BITS-1:0] pixel;
   } pixel_cmd_type;

   typedef struct {
      cmd_type                      cmd;
      logic [BIN_BITS-1:0]          pixel_out;
      logic [LEVEL_BITS-1:0]        low_level;
      logic signed [LEVEL_BITS-1:0] high_level;
      status_type                   status;
   } stretch_word_type;

   logic                         clock;
   logic                         reset       = 1'b1;
   logic                         req_valid   = 1'b0;
   logic                         req_stall;
   logic [1:0]                   req_cmd     = CMD_CLEAR;
   logic [BIN_BITS-1:0]          req_pixel   = '0;
   logic                         rsp_valid;
   logic                         rsp_stall   = 1'b0;
   logic [BIN_BITS-1:0]          rsp_pixel_out;
   logic [LEVEL_BITS-1:0]        rsp_low_level;
   logic signed [LEVEL_BITS-1:0] rsp_high_level;
   logic [1:0]                   rsp_status;
   logic                         csr_psel    = 1'b0;
   logic                         csr_penable = 1'b0;
   logic                         csr_pwrite  = 1'b0;
   logic [ADDR_BITS-1:0]         csr_paddr   = '0;
   logic [DATA_BITS-1:0]         csr_pwdata  = '0;
   logic [DATA_BITS-1:0]         csr_prdata;
   logic                         csr_pready;

   // model state
   logic [COUNT_BITS-1:0] bin_tally [NUM_BINS];
   logic [COUNT_BITS-1:0] pixel_tally;
   int                    level_lo;
   int                    level_hi;
   bit                    levels_ok;
   logic [CUT_BITS-1:0]   clip_frac;

   pixel_cmd_type    pending_words [$];
   stretch_word_type expected_words [$];
   pixel_cmd_type    next_word;
   stretch_word_type want;

   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int send_gap     = 0;
   int stall_left   = 0;
   int queued_items = 0;
   int words_sent   = 0;
   int words_checked = 0;
   int mismatches   = 0;
   int cycles       = 0;
   int csr_writes   = 0;
   int cmd_seen [4] = '{0, 0, 0, 0};
   int stretched_maps = 0;
   int invalid_seen   = 0;

   histogram_auto_levels_stretch i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_pixel      (req_pixel),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pixel_out  (rsp_pixel_out),
      .rsp_low_level  (rsp_low_level),
      .rsp_high_level (rsp_high_level),
      .rsp_status     (rsp_status),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic void clear_histogram();
      foreach (bin_tally[i]) bin_tally[i] = '0;
      pixel_tally = '0;
   endfunction

   function automatic logic [COUNT_BITS-1:0] bump_count(input logic [COUNT_BITS-1:0] v,
                                                        inout bit sat);
      if (v == {COUNT_BITS{1'b1}}) begin
         sat = 1'b1;
         return v;
      end
      return v + 1'b1;
   endfunction

   function automatic void find_levels();
      longint unsigned goal;
      longint unsigned acc;
      int              lo;
      int              hi;
      goal = longint'(clip_frac) * longint'(pixel_tally);
      acc  = 0;
      lo   = 0;
      while (lo < NUM_BINS && (acc << FRAC_BITS) < goal) begin
         acc += bin_tally[lo];
         lo++;
      end
      acc = 0;
      hi  = NUM_BINS - 1;
      while (hi >= 0 && (acc << FRAC_BITS) < goal) begin
         acc += bin_tally[hi];
         hi--;
      end
      level_lo  = lo;
      level_hi  = hi;
      levels_ok = (pixel_tally != 0) && (hi > lo);
   endfunction

   function automatic logic [BIN_BITS-1:0] stretch_pixel(input logic [BIN_BITS-1:0] x);
      longint num;
      longint den;
      longint q;
      longint r;
      num = 255 * (longint'(x) - longint'(level_lo));
      den = longint'(level_hi) - longint'(level_lo);
      if (num <= 0 || den <= 0) return '0;
      q = num / den;
      r = num % den;
      // round half to even
      if (2 * r > den || (2 * r == den && q[0])) q++;
      if (q > 255) q = 255;
      return BIN_BITS'(q);
   endfunction

   function automatic stretch_word_type stretch_predict(input cmd_type cmd,
                                                        input logic [BIN_BITS-1:0] pix);
      stretch_word_type w;
      bit               sat;
      w.cmd       = cmd;
      w.pixel_out = '0;
      w.status    = STATUS_OK;
      sat         = 1'b0;
      case (cmd)
         CMD_CLEAR: begin
            clear_histogram();
         end
         CMD_ACCUM: begin
            bin_tally[pix] = bump_count(bin_tally[pix], sat);
            pixel_tally    = bump_count(pixel_tally, sat);
            if (sat) w.status = STATUS_SAT;
         end
         CMD_COMPUTE: begin
            find_levels();
            if (!levels_ok) w.status = STATUS_INVALID;
         end
         default: begin
            if (levels_ok) begin
               w.pixel_out = stretch_pixel(pix);
            end else begin
               w.pixel_out = pix;
               w.status    = STATUS_INVALID;
            end
         end
      endcase
      w.low_level  = LEVEL_BITS'(level_lo);
      w.high_level = LEVEL_BITS'(level_hi);
      return w;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int exp_val);
      if (mismatches < MAX_REPORTS)
         $display("mismatch at word %0d: %s got %0d, wanted %0d",
                  words_checked, what, got, exp_val);
      mismatches++;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  = 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_words.push_back(stretch_predict(cmd_type'(req_cmd), req_pixel));
            words_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_words.size() > 0 && $urandom_range(99) < req_idle_pct) begin
               send_gap = $urandom_range(12);
               req_valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
               next_word = pending_words.pop_front();
               req_valid <= 1'b1;
               req_cmd   <= next_word.cmd;
               req_pixel <= next_word.pixel;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               report_mismatch("word with nothing expected, status", rsp_status, 0);
            end else begin
               want = expected_words.pop_front();
               if (rsp_pixel_out !== want.pixel_out)
                  report_mismatch("pixel_out", rsp_pixel_out, want.pixel_out);
               if (rsp_low_level !== want.low_level)
                  report_mismatch("low_level", rsp_low_level, want.low_level);
               if (rsp_high_level !== want.high_level)
                  report_mismatch("high_level", rsp_high_level, want.high_level);
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
               cmd_seen[want.cmd]++;
               if (want.cmd == CMD_MAP && want.status == STATUS_OK) stretched_maps++;
               if (want.status == STATUS_INVALID) invalid_seen++;
            end
            words_checked++;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if ($urandom_range(99) < rsp_idle_pct) begin
            stall_left = $urandom_range(12);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words outstanding",
                  cycles, expected_words.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic push_word(input cmd_type cmd, input int pix);
      pixel_cmd_type w;
      w.cmd   = cmd;
      w.pixel = BIN_BITS'(pix);
      pending_words.push_back(w);
      queued_items++;
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_words.size() != 0 || req_valid || expected_words.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_clip(input logic [CUT_BITS-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_CUT_ADDR;
      csr_pwdata  <= DATA_BITS'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      clip_frac = value;
      csr_writes++;
   endtask

   task automatic queue_frame();
      int n_acc;
      int n_map;
      int kind;
      int base;
      int top;
      int pix;
      if ($urandom_range(9) != 0) push_word(CMD_CLEAR, $urandom_range(255));
      n_acc = ($urandom_range(7) == 0) ? $urandom_range(60, 160) : $urandom_range(1, 40);
      kind  = $urandom_range(3);
      base  = $urandom_range(255);
      top   = base + $urandom_range(60);
      if (top > 255) top = 255;
      for (int i = 0; i < n_acc; i++) begin
         case (kind)
            0: pix = $urandom_range(255);
            1: pix = $urandom_range(base, top);
            2: pix = base;
            default: pix = $urandom_range(1) ? $urandom_range(15) : $urandom_range(240, 255);
         endcase
         push_word(CMD_ACCUM, pix);
      end
      push_word(CMD_COMPUTE, $urandom_range(255));
      n_map = $urandom_range(3, 12);
      for (int i = 0; i < n_map; i++) begin
         case ($urandom_range(9))
            0: pix = 0;
            1: pix = 255;
            default: pix = $urandom_range(255);
         endcase
         push_word(CMD_MAP, pix);
      end
   endtask

   task automatic run_phase(input logic [CUT_BITS-1:0] cut, input int req_pct,
                            input int rsp_pct);
      int goal;
      wait_drained();
      write_clip(cut);
      @(negedge clock);
      req_idle_pct = req_pct;
      rsp_idle_pct = rsp_pct;
      goal = queued_items + PHASE_WORDS;
      while (queued_items < goal) begin
         if ($urandom_range(4) == 0) begin
            // stray commands out of sequence
            repeat ($urandom_range(1, 5))
               push_word(cmd_type'($urandom_range(3)), $urandom_range(255));
         end
         queue_frame();
      end
   endtask

   initial begin
      foreach (bin_tally[i]) bin_tally[i] = '0;
      pixel_tally = '0;
      level_lo    = 0;
      level_hi    = 255;
      levels_ok   = 1'b0;
      clip_frac   = CUT_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset levels: map passes through, compute on empty histogram
      req_idle_pct = 20;
      rsp_idle_pct = 20;
      push_word(CMD_MAP, 0);
      push_word(CMD_MAP, 255);
      push_word(CMD_COMPUTE, 0);
      push_word(CMD_ACCUM, 0);
      push_word(CMD_ACCUM, 255);
      push_word(CMD_ACCUM, 128);
      push_word(CMD_ACCUM, 128);
      push_word(CMD_COMPUTE, 255);
      push_word(CMD_MAP, 0);
      push_word(CMD_MAP, 1);
      push_word(CMD_MAP, 127);
      push_word(CMD_MAP, 128);
      push_word(CMD_MAP, 254);
      push_word(CMD_MAP, 255);
      push_word(CMD_CLEAR, 170);
      push_word(CMD_COMPUTE, 85);
      push_word(CMD_MAP, 77);

      // zero clip: levels stay at the histogram ends
      wait_drained();
      write_clip('0);
      @(negedge clock);
      push_word(CMD_ACCUM, 10);
      push_word(CMD_ACCUM, 200);
      push_word(CMD_COMPUTE, 0);
      push_word(CMD_MAP, 10);
      push_word(CMD_MAP, 200);

      run_phase({CUT_BITS{1'b1}}, 25, 25);
      run_phase(CUT_BITS'($urandom_range(1, 32767)), 0, 0);
      run_phase(CUT_BITS'(6553), 40, 10);
      run_phase(CUT_BITS'(1), 10, 40);
      run_phase(CUT_BITS'($urandom_range(2000)), 30, 30);
      run_phase(CUT_RESET, 0, 0);

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("%0d words checked: %0d clear, %0d accumulate, %0d compute, %0d map",
               words_checked, cmd_seen[CMD_CLEAR], cmd_seen[CMD_ACCUM],
               cmd_seen[CMD_COMPUTE], cmd_seen[CMD_MAP]);
      $display("%0d maps stretched, %0d invalid-level words, %0d clip settings written",
               stretched_maps, invalid_seen, csr_writes);
      if (mismatches == 0 && expected_words.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
